>>> hdl/pdc_pkg.sv
package pdc_pkg;

  localparam int DISTANCE_WIDTH = 10;
  localparam int ERR_W          = DISTANCE_WIDTH + 1;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int SUM_W          = 18;
  localparam int SMAG_W         = SUM_W - 1;

  localparam int DIST_REG_W = 10;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 10;
  localparam int PER_W      = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int DUTY_MAX = 999;
  localparam int MS_PER_S = 1000;

  // Q.16 bracket and its parts
  localparam int FRAC_P    = 16;
  localparam int FRAC_I    = 24;
  localparam int DSCALE_SH = 11;  // 256000 = 125 << 11
  localparam int DSCALE_K  = 125;
  localparam int INUM_W    = PER_W + SMAG_W;
  localparam int DEN_W     = GAIN_W + 10;
  localparam int TDD_W     = GAIN_W + DIFF_W;
  localparam int DNUM_W    = TDD_W + 7 + DSCALE_SH;

  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = DEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int BR_W     = 50;
  localparam int BR_MAG_W = 47;
  localparam int MUL_LO_W = 24;
  localparam int MUL_HI_W = BR_MAG_W - MUL_LO_W;
  localparam int PROD_W   = GAIN_W + MUL_LO_W;
  localparam int ACC_W    = GAIN_W + BR_MAG_W;
  localparam int FIN_W    = ACC_W + 2;
  localparam int OUT_SH   = 24;

  localparam logic signed [BR_W-1:0] BR_SAT = {{(BR_W-47){1'b0}}, 1'b1, 46'b0};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_TI       = 3'd2,
    REG_TD       = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_OFFSET   = 3'd5,
    REG_PERIOD   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SUM,
    S_MUL_LO,
    S_MUL_HI,
    S_FINAL
  } pdc_state_e;

  typedef struct packed {
    logic take;
    logic calc;
    logic prep;
    logic div_start;
    logic sum;
    logic mul_lo;
    logic mul_hi;
    logic final_wr;
  } pdc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } pdc_status_t;

endpackage

>>> hdl/pdc_ifs.sv
interface pdc_in_if import pdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DISTANCE_WIDTH-1:0] measured_distance;

  modport source (output valid, output measured_distance, input ready);
  modport sink   (input valid, input measured_distance, output ready);
endinterface

interface pdc_out_if import pdc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DUTY_W-1:0]         duty_value;
  logic signed [ERR_W-1:0]   control_error;
  logic [DISTANCE_WIDTH-1:0] distance_echo;

  modport source (output valid, output duty_value, output control_error,
                  output distance_echo, input ready);
  modport sink   (input valid, input duty_value, input control_error,
                  input distance_echo, output ready);
endinterface

>>> hdl/pdc_divider.sv
module pdc_divider import pdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quotient_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] div_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;
  logic [DIV_DEN_W-1:0] rem_nx;

  // restoring step: one quotient bit a cycle, shifted in behind the dividend
  assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};
  assign rem_nx = fits ? DIV_DEN_W'(rem_sh - {1'b0, div_q}) : DIV_DEN_W'(rem_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("divider started while busy");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == DIV_CNT_W'(1)) |=> done_q)
    else $error("divider done missing after last step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> rem_q < div_q)
    else $error("partial remainder not below divisor");

endmodule

>>> hdl/pdc_datapath.sv
module pdc_datapath import pdc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [DISTANCE_WIDTH-1:0]  dist_i,
  input  logic                       out_ready_i,
  input  pdc_cmd_t                   cmd_i,
  output pdc_status_t                status_o,
  output logic                       out_valid_o,
  output logic [DUTY_W-1:0]          duty_o,
  output logic signed [ERR_W-1:0]    err_o,
  output logic [DISTANCE_WIDTH-1:0]  echo_o
);

  // configuration
  logic [DIST_REG_W-1:0] tgt_q;
  logic [GAIN_W-1:0]     kp_q, ti_q, td_q, lim_q;
  logic [DUTY_W-1:0]     off_q;
  logic [PER_W-1:0]      per_q;

  // controller state
  logic signed [SUM_W-1:0] sum_q;
  logic signed [ERR_W-1:0] prev_q;

  // working registers
  logic [DISTANCE_WIDTH-1:0] dist_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic [INUM_W-1:0]         inum_q;
  logic [DEN_W-1:0]          den_q;
  logic [TDD_W-1:0]          tdd_q;
  logic [PER_W-1:0]          per_eff_q;
  logic                      isgn_q, dsgn_q;
  logic [BR_MAG_W-1:0]       br_mag_q;
  logic                      br_neg_q;
  logic [ACC_W-1:0]          acc_q;

  // output register
  logic                      out_valid_q;
  logic [DUTY_W-1:0]         duty_q;
  logic signed [ERR_W-1:0]   err_out_q;
  logic [DISTANCE_WIDTH-1:0] echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      kp_q  <= GAIN_W'(256);
      ti_q  <= GAIN_W'(256);
      td_q  <= '0;
      lim_q <= GAIN_W'(1000);
      off_q <= DUTY_W'(500);
      per_q <= PER_W'(50);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET: tgt_q <= DIST_REG_W'(cfg_data_i);
        REG_KP:     kp_q  <= GAIN_W'(cfg_data_i);
        REG_TI:     ti_q  <= GAIN_W'(cfg_data_i);
        REG_TD:     td_q  <= GAIN_W'(cfg_data_i);
        REG_LIMIT:  lim_q <= GAIN_W'(cfg_data_i);
        REG_OFFSET: off_q <= DUTY_W'(cfg_data_i);
        REG_PERIOD: per_q <= PER_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // error, clamped sum and difference
  logic [DISTANCE_WIDTH-1:0] tgt_m;
  logic signed [ERR_W-1:0]   e_d;
  logic signed [SUM_W:0]     sum_ext, lim_s;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [DIFF_W-1:0]  diff_d;

  assign tgt_m   = DISTANCE_WIDTH'(tgt_q);
  assign e_d     = $signed({1'b0, tgt_m}) - $signed({1'b0, dist_q});
  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(e_d);
  assign lim_s   = $signed((SUM_W+1)'(lim_q));
  assign diff_d  = DIFF_W'(prev_q) - DIFF_W'(e_d);

  always_comb begin
    if (sum_ext > lim_s) begin
      sum_d = SUM_W'(lim_s);
    end else if (sum_ext < -lim_s) begin
      sum_d = SUM_W'(-lim_s);
    end else begin
      sum_d = SUM_W'(sum_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (cmd_i.calc) begin
      sum_q  <= sum_d;
      prev_q <= e_d;
    end
  end

  // operands of the two divisions
  logic [SMAG_W-1:0] s_mag;
  logic [DIFF_W-1:0] d_mag;
  logic [PER_W-1:0]  per_eff;
  logic [GAIN_W-1:0] ti_eff;

  assign s_mag   = sum_q[SUM_W-1] ? SMAG_W'(-sum_q) : SMAG_W'(sum_q);
  assign d_mag   = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign per_eff = (per_q == '0) ? PER_W'(1) : per_q;
  assign ti_eff  = (ti_q == '0) ? GAIN_W'(1) : ti_q;

  logic [DNUM_W-1:0]    dnum;
  logic [DIV_NUM_W-1:0] idiv_num, ddiv_num, iq, dq;
  logic                 idone, ddone;

  assign dnum     = DNUM_W'((DNUM_W'(tdd_q) * DNUM_W'(DSCALE_K)) << DSCALE_SH);
  assign idiv_num = DIV_NUM_W'(DIV_NUM_W'(inum_q) << FRAC_I);
  assign ddiv_num = DIV_NUM_W'(dnum);

  pdc_divider u_idiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (idiv_num),
    .divisor_i  (den_q),
    .done_o     (idone),
    .quotient_o (iq)
  );

  pdc_divider u_ddiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ddiv_num),
    .divisor_i  (DIV_DEN_W'(per_eff_q)),
    .done_o     (ddone),
    .quotient_o (dq)
  );

  // bracket, saturated to +-2^46
  logic signed [BR_W-1:0] p_term, i_term, d_term, br, br_sat;

  assign p_term = BR_W'(err_q) <<< FRAC_P;
  assign i_term = isgn_q ? -$signed(BR_W'(iq)) : $signed(BR_W'(iq));
  assign d_term = dsgn_q ? -$signed(BR_W'(dq)) : $signed(BR_W'(dq));
  assign br     = p_term + i_term + d_term;

  always_comb begin
    if (br > BR_SAT) begin
      br_sat = BR_SAT;
    end else if (br < -BR_SAT) begin
      br_sat = -BR_SAT;
    end else begin
      br_sat = br;
    end
  end

  // Kp times bracket magnitude in two halves on one multiplier
  logic [MUL_LO_W-1:0] mul_op;
  logic [PROD_W-1:0]   prod;

  assign mul_op = cmd_i.mul_hi ? MUL_LO_W'(br_mag_q[BR_MAG_W-1:MUL_LO_W])
                               : br_mag_q[MUL_LO_W-1:0];
  assign prod   = PROD_W'(kp_q) * PROD_W'(mul_op);

  // drive: (offset << 24 -+ product) >> 24, clamped
  logic [FIN_W-1:0]  off_sh, accx, fin, fin_q;
  logic              fin_neg;
  logic [DUTY_W-1:0] duty_d;

  assign off_sh  = FIN_W'(off_q) << OUT_SH;
  assign accx    = FIN_W'(acc_q);
  assign fin     = br_neg_q ? off_sh + accx : off_sh - accx;
  assign fin_neg = !br_neg_q && (accx > off_sh);
  assign fin_q   = fin >> OUT_SH;
  assign duty_d  = fin_neg ? '0
                 : (fin_q > FIN_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(fin_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      dist_q <= dist_i;
    end
    if (cmd_i.calc) begin
      err_q  <= e_d;
      diff_q <= diff_d;
    end
    if (cmd_i.prep) begin
      inum_q    <= INUM_W'(per_eff) * INUM_W'(s_mag);
      den_q     <= DEN_W'(ti_eff) * DEN_W'(MS_PER_S);
      tdd_q     <= TDD_W'(td_q) * TDD_W'(d_mag);
      per_eff_q <= per_eff;
      isgn_q    <= sum_q[SUM_W-1];
      dsgn_q    <= diff_q[DIFF_W-1];
    end
    if (cmd_i.sum) begin
      br_neg_q <= br_sat[BR_W-1];
      br_mag_q <= br_sat[BR_W-1] ? BR_MAG_W'(-br_sat) : BR_MAG_W'(br_sat);
    end
    if (cmd_i.mul_lo) begin
      acc_q <= ACC_W'(prod);
    end else if (cmd_i.mul_hi) begin
      acc_q <= acc_q + ACC_W'(ACC_W'(prod) << MUL_LO_W);
    end
    if (cmd_i.final_wr) begin
      duty_q    <= duty_d;
      err_out_q <= err_q;
      echo_q    <= dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.final_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_done = idone & ddone;
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign err_o       = err_out_q;
  assign echo_o      = echo_q;

endmodule

>>> hdl/pdc_ctrl.sv
module pdc_ctrl import pdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  pdc_status_t status_i,
  output logic        in_ready_o,
  output pdc_cmd_t    cmd_o
);

  pdc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_CALC;
      S_CALC:     state_d = S_PREP;
      S_PREP:     state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (status_i.div_done) state_d = S_SUM;
      S_SUM:      state_d = S_MUL_LO;
      S_MUL_LO:   state_d = S_MUL_HI;
      S_MUL_HI:   state_d = S_FINAL;
      S_FINAL:    if (!status_i.out_busy) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      S_CALC:   cmd_o.calc = 1'b1;
      S_PREP:   cmd_o.prep = 1'b1;
      S_DIV_GO: cmd_o.div_start = 1'b1;
      S_SUM:    cmd_o.sum = 1'b1;
      S_MUL_LO: cmd_o.mul_lo = 1'b1;
      S_MUL_HI: cmd_o.mul_hi = 1'b1;
      // result waits here while the previous item is still unclaimed
      S_FINAL:  cmd_o.final_wr = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

>>> hdl/pid_duty_controller_top.sv
// One item is worked on at a time: a new item is taken only once the previous
// result is in the output register. The integral and derivative terms come from
// 52-step radix-2 dividers that run side by side.
// A new item may be taken while the previous result still waits at the output.
// Reset (rst_ni low, asynchronous) restores register defaults, clears the error
// sum and previous error, and empties the output.
module pid_duty_controller_top import pdc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pdc_in_if.sink                in_i,
  pdc_out_if.source             out_o
);

  pdc_cmd_t    cmd;
  pdc_status_t status;
  logic        in_ready;

  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  pdc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .dist_i      (in_i.measured_distance),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .duty_o      (out_o.duty_value),
    .err_o       (out_o.control_error),
    .echo_o      (out_o.distance_echo)
  );

  assign in_i.ready = in_ready;

endmodule

>>> test/pid_duty_controller_top_tb.sv
`timescale 1ns / 100ps

module pid_duty_controller_top_tb;
  import pdc_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 5000;
  localparam int                   DRAIN_CYCLES   = 80;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE      = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0]         duty;
    logic signed [ERR_W-1:0]   err;
    logic [DISTANCE_WIDTH-1:0] echo;
  } drive_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pdc_in_if  in_if ();
  pdc_out_if out_if ();

  pid_duty_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // controller settings and state as the block should hold them
  longint tgt_mm, kp_q88, ti_q88, td_q88, sum_limit, duty_bias, period_ms;
  longint err_sum, last_err;

  drive_result_t drive_q[$];
  int            fail_count;
  int            idle_cycles;
  bit            in_idle, out_idle;
  int            rx_hold, rx_gap;

  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic drive_result_t compute_drive(input logic [DISTANCE_WIDTH-1:0] dist_mm);
    longint        e, ti, per, diff, br, total;
    drive_result_t r;
    e   = tgt_mm - longint'(dist_mm);
    ti  = (ti_q88 == 0) ? 64'sd1 : ti_q88;
    per = (period_ms == 0) ? 64'sd1 : period_ms;
    err_sum = err_sum + e;
    if (err_sum > sum_limit) err_sum = sum_limit;
    if (err_sum < -sum_limit) err_sum = -sum_limit;
    diff = last_err - e;
    // bracket in Q.16: P + I + D
    br = e * 64'sd65536;
    br = br + (per * err_sum * 64'sd16777216) / (MS_PER_S * ti);
    br = br + (td_q88 * diff * 64'sd256000) / per;
    if (br > (64'sd1 <<< 46)) br = 64'sd1 <<< 46;
    if (br < -(64'sd1 <<< 46)) br = -(64'sd1 <<< 46);
    total = (duty_bias * 64'sd16777216 - kp_q88 * br) / 64'sd16777216;
    if (total > DUTY_MAX) total = DUTY_MAX;
    if (total < 0) total = 0;
    last_err = e;
    r.duty = total[DUTY_W-1:0];
    r.err  = e[ERR_W-1:0];
    r.echo = dist_mm;
    return r;
  endfunction

  // input and output acceptance, checking and watchdog
  always @(posedge clk_i) begin
    drive_result_t want;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        drive_q.push_back(compute_drive(in_if.measured_distance));
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (drive_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result duty=%0d err=%0d dist=%0d", $realtime,
                     out_if.duty_value, out_if.control_error, out_if.distance_echo);
        end else begin
          want = drive_q.pop_front();
          if (out_if.duty_value !== want.duty || out_if.control_error !== want.err ||
              out_if.distance_echo !== want.echo) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp duty=%0d err=%0d dist=%0d got duty=%0d err=%0d dist=%0d",
                       $realtime, want.duty, want.err, want.echo, out_if.duty_value,
                       out_if.control_error, out_if.distance_echo);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_if.ready = 1'b0;
        rx_gap--;
      end else begin
        out_if.ready = 1'b1;
        rx_gap = pick_gap(out_idle);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      REG_TARGET: tgt_mm    = longint'(val[DIST_REG_W-1:0]);
      REG_KP:     kp_q88    = longint'(val);
      REG_TI:     ti_q88    = longint'(val);
      REG_TD:     td_q88    = longint'(val);
      REG_LIMIT:  sum_limit = longint'(val);
      REG_OFFSET: duty_bias = longint'(val[DUTY_W-1:0]);
      REG_PERIOD: period_ms = longint'(val[PER_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_distance(input logic [DISTANCE_WIDTH-1:0] d);
    int gap;
    gap = pick_gap(in_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid             = 1'b1;
    in_if.measured_distance = d;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop offering, wait for every outstanding result, let the pipeline go quiet
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_reset_defaults();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_distance(10'd0);
    send_distance(10'd1023);
    send_distance(10'd1023);
    send_distance(10'd0);
    send_distance(10'd512);
    settle();
  endtask

  task automatic test_register_extremes();
    // upper data bits set on a 10-bit register, zero Ti, zero period,
    // zero limit, offset above range, write to the unused index
    write_reg(REG_TARGET, 16'hFFFF);
    write_reg(REG_KP, 16'hFFFF);
    write_reg(REG_TI, 16'd0);
    write_reg(REG_TD, 16'hFFFF);
    write_reg(REG_LIMIT, 16'd0);
    write_reg(REG_OFFSET, 16'd1023);
    write_reg(REG_PERIOD, 16'd0);
    write_reg(IDX_SPARE, 16'hA5A5);
    in_idle = 1'b1;
    send_distance(10'd0);
    send_distance(10'd1023);
    send_distance(10'd0);
    send_distance(10'd1023);
    send_distance(10'd1023);
    settle();
    write_reg(REG_TARGET, 16'd0);
    write_reg(REG_KP, 16'd1);
    write_reg(REG_TI, 16'd1);
    write_reg(REG_TD, 16'd0);
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_OFFSET, 16'd0);
    write_reg(REG_PERIOD, 16'd1023);
    out_idle = 1'b1;
    send_distance(10'd1023);
    send_distance(10'd1023);
    send_distance(10'd1023);
    send_distance(10'd0);
    send_distance(10'd512);
    settle();
    write_reg(REG_TARGET, 16'd512);
    write_reg(REG_KP, 16'd256);
    write_reg(REG_TI, 16'hFFFF);
    write_reg(REG_TD, 16'd1);
    write_reg(REG_LIMIT, 16'd5);
    write_reg(REG_OFFSET, 16'd999);
    write_reg(REG_PERIOD, 16'd1000);
    send_distance(10'd500);
    send_distance(10'd520);
    send_distance(10'd512);
    send_distance(10'd0);
    send_distance(10'd1023);
    send_distance(10'd511);
    settle();
  endtask

  task automatic test_output_backpressure();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    @(posedge clk_i);
    rx_hold = 400;
    repeat (8) send_distance(DISTANCE_WIDTH'($urandom));
    settle();
  endtask

  task automatic pick_settings();
    logic [5:0] junk;
    junk = 6'($urandom);
    case ($urandom_range(0, 9))
      0:       write_reg(REG_TARGET, {junk, 10'($urandom)});
      1:       write_reg(REG_TARGET, 16'd1023);
      default: write_reg(REG_TARGET, 16'($urandom_range(0, 1023)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_KP, 16'd0);
      1:       write_reg(REG_KP, 16'hFFFF);
      default: write_reg(REG_KP, 16'($urandom_range(1, 600)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_TI, 16'd0);
      1:       write_reg(REG_TI, 16'd1);
      2:       write_reg(REG_TI, 16'hFFFF);
      default: write_reg(REG_TI, 16'($urandom_range(64, 4096)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_TD, 16'd0);
      1:       write_reg(REG_TD, 16'hFFFF);
      default: write_reg(REG_TD, 16'($urandom_range(0, 2000)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_LIMIT, 16'd0);
      1:       write_reg(REG_LIMIT, 16'hFFFF);
      default: write_reg(REG_LIMIT, 16'($urandom_range(1, 3000)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_OFFSET, 16'd0);
      1:       write_reg(REG_OFFSET, 16'd999);
      2:       write_reg(REG_OFFSET, {junk, 10'($urandom_range(1000, 1023))});
      default: write_reg(REG_OFFSET, 16'($urandom_range(0, 999)));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_PERIOD, 16'd0);
      1:       write_reg(REG_PERIOD, 16'd1);
      2:       write_reg(REG_PERIOD, 16'($urandom_range(1000, 1023)));
      default: write_reg(REG_PERIOD, 16'($urandom_range(1, 1000)));
    endcase
  endtask

  task automatic test_random_tracking(input int phases, input int per_phase);
    int pos;
    for (int p = 0; p < phases; p++) begin
      pick_settings();
      in_idle  = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
      out_idle = (p % 4 != 0) && ($urandom_range(0, 3) != 0);
      pos = int'(tgt_mm) + $urandom_range(0, 60) - 30;
      for (int k = 0; k < per_phase; k++) begin
        // mostly a ball wandering near the setpoint, sometimes a wild reading
        if ($urandom_range(0, 9) < 7) begin
          pos = pos + $urandom_range(0, 16) - 8;
          pos = pos + ((int'(tgt_mm) - pos) >>> 3);
          if (pos < 0) pos = 0;
          if (pos > 1023) pos = 1023;
          send_distance(DISTANCE_WIDTH'(pos));
        end else begin
          send_distance(DISTANCE_WIDTH'($urandom));
        end
      end
      settle();
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_TARGET;
    cfg_data_i              = '0;
    in_if.valid             = 1'b0;
    in_if.measured_distance = '0;
    in_idle                 = 1'b0;
    out_idle                = 1'b0;
    rx_hold                 = 0;
    fail_count              = 0;
    idle_cycles             = 0;
    tgt_mm    = 0;
    kp_q88    = 256;
    ti_q88    = 256;
    td_q88    = 0;
    sum_limit = 1000;
    duty_bias = 500;
    period_ms = 50;
    err_sum   = 0;
    last_err  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_tracking(12, 152);

    if (drive_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pdc_pkg.sv
hdl/pdc_ifs.sv
hdl/pdc_divider.sv
hdl/pdc_datapath.sv
hdl/pdc_ctrl.sv
hdl/pid_duty_controller_top.sv
test/pid_duty_controller_top_tb.sv
